FILE: rtl/psss_pkg.sv
// ----------------------------------------------------------------------------
// psss_pkg: shared types and constants for the prime and square stream stats
// Widths of the classified value, the root and the shared compare-subtract
// unit. Also the beat structs of both channels and the engine status.
// ----------------------------------------------------------------------------
package psss_pkg;

    localparam int VALUE_BITS = 16;
    localparam int FIELD_BITS = 16;
    localparam int COUNT_BITS = 16;
    localparam int ROOT_BITS  = (VALUE_BITS + 1) / 2;
    localparam int SQ_BITS    = 2 * ROOT_BITS;
    localparam int UNIT_BITS  = ROOT_BITS + 3;
    localparam int CNT_BITS   = $clog2(SQ_BITS);

    typedef struct packed {
        logic [FIELD_BITS-1:0] value;
        logic                  last;
    } psss_in_t;

    typedef struct packed {
        logic                  prime_flag;
        logic                  is_square;
        logic [COUNT_BITS-1:0] prime_count;
        logic [COUNT_BITS-1:0] square_count;
        logic [FIELD_BITS-1:0] smallest_prime;
        logic                  any_prime;
    } psss_out_t;

    typedef struct packed {
        logic idle;
        logic done;
        logic prime_flag;
        logic is_square;
    } psss_eng_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SQRT = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } psss_state_t;

endpackage

FILE: rtl/psss_cmpsub.sv
// ----------------------------------------------------------------------------
// psss_cmpsub: shared compare-subtract unit
// Compares a trial operand against the partial remainder and gives the
// difference; serves both the root digits and the trial division bits.
// ----------------------------------------------------------------------------
module psss_cmpsub
    import psss_pkg::*;
(
    input  logic [UNIT_BITS-1:0] a,
    input  logic [UNIT_BITS-1:0] b,
    output logic                 ge,
    output logic [UNIT_BITS-1:0] diff
);

    logic [UNIT_BITS:0] wide;

    assign wide = {1'b0, a} - {1'b0, b};
    assign ge   = ~wide[UNIT_BITS];
    assign diff = wide[UNIT_BITS-1:0];

endmodule

FILE: rtl/psss_engine.sv
// ----------------------------------------------------------------------------
// psss_engine: square root and trial division sequencer
// Takes the integer root two bits a cycle, then on the shared unit divides by
// each candidate from 2 to the root until one divides, a quotient bit a cycle.
// ----------------------------------------------------------------------------
module psss_engine
    import psss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  ack,
    output psss_eng_t             status
);

    psss_state_t           state_reg, state_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [SQ_BITS-1:0]    shv_reg, shv_next;
    logic [UNIT_BITS-1:0]  rem_reg, rem_next;
    logic [ROOT_BITS-1:0]  root_reg, root_next;
    logic [ROOT_BITS-1:0]  div_reg, div_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  prime_reg, prime_next;
    logic                  square_reg, square_next;

    logic [UNIT_BITS-1:0]  unit_a;
    logic [UNIT_BITS-1:0]  unit_b;
    logic                  unit_ge;
    logic [UNIT_BITS-1:0]  unit_diff;
    logic [UNIT_BITS-1:0]  rem_step;
    logic [ROOT_BITS-1:0]  root_step;

    psss_cmpsub u_cmpsub (
        .a    (unit_a),
        .b    (unit_b),
        .ge   (unit_ge),
        .diff (unit_diff)
    );

    always_comb
    begin
        if (state_reg == ST_DIV)
        begin
            unit_a = {rem_reg[UNIT_BITS-2:0], shv_reg[SQ_BITS-1]};
            unit_b = UNIT_BITS'(div_reg);
        end
        else
        begin
            unit_a = {rem_reg[UNIT_BITS-3:0], shv_reg[SQ_BITS-1 -: 2]};
            unit_b = {1'b0, root_reg, 2'b01};
        end
        rem_step  = unit_ge ? unit_diff : unit_a;
        root_step = {root_reg[ROOT_BITS-2:0], unit_ge};
    end

    always_comb
    begin
        state_next  = state_reg;
        value_next  = value_reg;
        shv_next    = shv_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        div_next    = div_reg;
        cnt_next    = cnt_reg;
        prime_next  = prime_reg;
        square_next = square_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    value_next = value;
                    shv_next   = SQ_BITS'(value);
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = CNT_BITS'(ROOT_BITS - 1);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                shv_next  = shv_reg << 2;
                rem_next  = rem_step;
                root_next = root_step;
                cnt_next  = cnt_reg - CNT_BITS'(1);
                if (cnt_reg == '0)
                begin
                    square_next = (rem_step == '0);
                    if (value_reg < VALUE_BITS'(2))
                    begin
                        prime_next = 1'b0;
                        state_next = ST_DONE;
                    end
                    else if (root_step < ROOT_BITS'(2))
                    begin
                        prime_next = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        div_next   = ROOT_BITS'(2);
                        rem_next   = '0;
                        shv_next   = SQ_BITS'(value_reg);
                        cnt_next   = CNT_BITS'(SQ_BITS - 1);
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                shv_next = shv_reg << 1;
                rem_next = rem_step;
                cnt_next = cnt_reg - CNT_BITS'(1);
                if (cnt_reg == '0)
                begin
                    if (rem_step == '0)
                    begin
                        prime_next = 1'b0;
                        state_next = ST_DONE;
                    end
                    else if (div_reg == root_reg)
                    begin
                        prime_next = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        div_next = div_reg + ROOT_BITS'(1);
                        rem_next = '0;
                        shv_next = SQ_BITS'(value_reg);
                        cnt_next = CNT_BITS'(SQ_BITS - 1);
                    end
                end
            end
            ST_DONE:
            begin
                if (ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        shv_reg    <= shv_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        div_reg    <= div_next;
        cnt_reg    <= cnt_next;
        prime_reg  <= prime_next;
        square_reg <= square_next;
    end

    assign status.idle       = (state_reg == ST_IDLE);
    assign status.done       = (state_reg == ST_DONE);
    assign status.prime_flag = prime_reg;
    assign status.is_square  = square_reg;

endmodule

FILE: rtl/prime_and_square_stream_stats_core.sv
// ----------------------------------------------------------------------------
// prime_and_square_stream_stats_core: prime and square stream statistics
// Classifies each value as prime and as perfect square, keeps running set
// counts and the smallest prime, and returns one result beat per item.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid, item_stall, item) carries a value and a
//   last-of-set flag. result channel (result_valid, result_stall, result)
//   returns one beat per item, in order.
//   The engine takes one item at a time. It takes the root first, then
//   tries each divisor from two up to the integer root on the shared
//   compare-subtract unit, stopping at the first that divides the value.
//   Values below 4 skip trial division.
//   item_stall is high while the engine works or holds a finished result.
//   A finished result moves into the result register when it is empty or
//   being taken; while result_stall is high the beat holds and the engine
//   waits in its done state.
//   Reset clears counts, smallest prime and the prime-seen flag; the same
//   happens after the result of an item marked last.
// ----------------------------------------------------------------------------
module prime_and_square_stream_stats_core
    import psss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  psss_in_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output psss_out_t result
);

    psss_eng_t             eng;
    logic                  take;
    logic                  ack;

    logic [VALUE_BITS-1:0] value_reg;
    logic                  last_reg;
    logic                  result_valid_reg, result_valid_next;
    psss_out_t             result_reg, result_next;

    logic [COUNT_BITS-1:0] prime_total_reg, prime_total_next;
    logic [COUNT_BITS-1:0] square_total_reg, square_total_next;
    logic [VALUE_BITS-1:0] least_prime_reg, least_prime_next;
    logic                  prime_seen_reg, prime_seen_next;

    logic [COUNT_BITS-1:0] prime_upd;
    logic [COUNT_BITS-1:0] square_upd;
    logic [VALUE_BITS-1:0] least_upd;
    logic                  seen_upd;

    assign item_stall = ~eng.idle;
    assign take       = item_valid & ~item_stall;
    assign ack        = eng.done & (~result_valid_reg | ~result_stall);

    psss_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (take),
        .value  (VALUE_BITS'(item.value)),
        .ack    (ack),
        .status (eng)
    );

    always_comb
    begin
        prime_upd  = prime_total_reg;
        square_upd = square_total_reg;
        least_upd  = least_prime_reg;
        seen_upd   = prime_seen_reg;
        if (eng.prime_flag)
        begin
            if (prime_total_reg != '1)
            begin
                prime_upd = prime_total_reg + COUNT_BITS'(1);
            end
            if (!prime_seen_reg || (value_reg < least_prime_reg))
            begin
                least_upd = value_reg;
            end
            seen_upd = 1'b1;
        end
        if (eng.is_square && (square_total_reg != '1))
        begin
            square_upd = square_total_reg + COUNT_BITS'(1);
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        prime_total_next  = prime_total_reg;
        square_total_next = square_total_reg;
        least_prime_next  = least_prime_reg;
        prime_seen_next   = prime_seen_reg;
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
        if (ack)
        begin
            result_valid_next          = 1'b1;
            result_next.prime_flag     = eng.prime_flag;
            result_next.is_square      = eng.is_square;
            result_next.prime_count    = prime_upd;
            result_next.square_count   = square_upd;
            result_next.smallest_prime = seen_upd ? FIELD_BITS'(least_upd) : '0;
            result_next.any_prime      = seen_upd;
            if (last_reg)
            begin
                prime_total_next  = '0;
                square_total_next = '0;
                least_prime_next  = '0;
                prime_seen_next   = 1'b0;
            end
            else
            begin
                prime_total_next  = prime_upd;
                square_total_next = square_upd;
                least_prime_next  = least_upd;
                prime_seen_next   = seen_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            prime_total_reg  <= '0;
            square_total_reg <= '0;
            least_prime_reg  <= '0;
            prime_seen_reg   <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            prime_total_reg  <= prime_total_next;
            square_total_reg <= square_total_next;
            least_prime_reg  <= least_prime_next;
            prime_seen_reg   <= prime_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (take)
        begin
            value_reg <= VALUE_BITS'(item.value);
            last_reg  <= item.last;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.prime_flag |-> !result_reg.is_square)
    else $error("prime result also flagged as square");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.prime_flag |->
            result_reg.any_prime && (result_reg.prime_count != '0))
    else $error("prime result without prime statistics");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.any_prime |->
            (result_reg.smallest_prime == '0) && (result_reg.prime_count == '0))
    else $error("prime statistics set with no prime seen");

    assert property (@(posedge clk) disable iff (!rst_n)
        ack |=> result_valid_reg && eng.idle)
    else $error("finished result not moved to result register");

endmodule
